@@ rtl/core/psb_pkg.sv @@
// ----------------------------------------------------------------------------
// psb_pkg
// Shared constants and types for the particle set bounds block.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int unsigned MaxParticles = 4096;
  localparam int unsigned AddrW        = $clog2(MaxParticles);
  localparam int unsigned CntW         = 13;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned SmoothW      = 31;
  localparam int unsigned SumW         = 44;
  localparam int unsigned SqW          = 64;
  localparam int unsigned RootW        = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_RD,
    ST_WALK,
    ST_SQRT,
    ST_OUT
  } psb_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [SmoothW-1:0]       smooth_len;
    logic                     is_last;
  } psb_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic signed [CoordW-1:0] centre_z;
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [RootW-1:0]         radius;
    logic [SmoothW-1:0]       max_smooth;
    logic [CntW-1:0]          count;
  } psb_out_t;

endpackage

@@ rtl/core/psb_if.sv @@
// ----------------------------------------------------------------------------
// psb_in_if / psb_out_if
// Valid/ready channels carrying particle beats and result beats.
// ----------------------------------------------------------------------------
interface psb_in_if;
  logic             valid;
  logic             ready;
  psb_pkg::psb_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psb_out_if;
  logic              valid;
  logic              ready;
  psb_pkg::psb_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/particle_set_bounds.sv @@
// ----------------------------------------------------------------------------
// particle_set_bounds
// Centroid, bounding box and bounding sphere of a particle set.
//
//  channel  dir  beat                               handshake
//  in_ch    in   pos_x/y/z, smooth_len, is_last     valid/ready
//  out_ch   out  centre, min, max, radius, ...      valid/ready
//
// A non-last particle is stored and accumulated. After the last one the
// block runs restoring division of each axis sum by the count, then per
// particle a read and a square per axis, then 32 square-root steps.
// Reset is async; the store needs no clearing. Input is stalled from the
// last particle until the result beat is taken.
// ----------------------------------------------------------------------------
module particle_set_bounds (
  input logic      clk_i,
  input logic      rst_ni,
  psb_in_if.sink   in_ch,
  psb_out_if.source out_ch
);
  localparam int unsigned AW = psb_pkg::AddrW;
  localparam int unsigned CW = psb_pkg::CoordW;
  localparam int unsigned SW = psb_pkg::SumW;
  localparam int unsigned NW = psb_pkg::CntW;

  psb_pkg::psb_state_e state_q, state_d;

  logic signed [SW-1:0] sum_q [3];
  logic signed [CW-1:0] lo_q [3], hi_q [3], ctr_q [3];
  logic [psb_pkg::SmoothW-1:0] smax_q;
  logic [NW-1:0]   cnt_q;
  logic [AW-1:0]   idx_q;
  logic [1:0]      axis_q;
  logic [5:0]      step_q;
  logic [SW-1:0]   quo_q;
  logic [NW:0]     rem_q;
  logic            neg_q;
  logic [63:0]     dist_q, best_q, rad_v_q;
  logic [31:0]     root_q;
  logic [31:0]     rrem_q;
  logic signed [CW-1:0] rd_x, rd_y, rd_z;

  logic acc_in, full;
  logic [AW-1:0] addr;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign full   = (cnt_q == NW'(psb_pkg::MaxParticles));
  assign addr   = (state_q == psb_pkg::ST_LOAD) ? cnt_q[AW-1:0] : idx_q;

  logic we;
  assign we = acc_in && !full;

  psb_ram #(.Width(CW), .Depth(psb_pkg::MaxParticles)) u_ram_x (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(in_ch.data.pos_x), .rdata_o(rd_x));
  psb_ram #(.Width(CW), .Depth(psb_pkg::MaxParticles)) u_ram_y (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(in_ch.data.pos_y), .rdata_o(rd_y));
  psb_ram #(.Width(CW), .Depth(psb_pkg::MaxParticles)) u_ram_z (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(in_ch.data.pos_z), .rdata_o(rd_z));

  // division datapath: restoring, one quotient bit per cycle on |sum|
  logic signed [SW-1:0] div_src;
  logic [SW-1:0] div_abs;
  logic [NW:0] rem_sh;
  logic        rem_ge;
  assign div_src = sum_q[axis_q];
  assign div_abs = div_src[SW-1] ? SW'(-div_src) : div_src;
  assign rem_sh  = {rem_q[NW-1:0], quo_q[SW-1]};
  assign rem_ge  = rem_sh >= {1'b0, cnt_q};

  // distance: one square per cycle from the held registered read
  logic signed [CW:0] diff;
  logic [CW-1:0] dmag;
  logic [63:0] sq;
  logic [64:0] dsum;
  always_comb begin
    unique case (axis_q)
      2'd0:    diff = (CW+1)'(ctr_q[0]) - (CW+1)'(rd_x);
      2'd1:    diff = (CW+1)'(ctr_q[1]) - (CW+1)'(rd_y);
      default: diff = (CW+1)'(ctr_q[2]) - (CW+1)'(rd_z);
    endcase
    dmag = diff[CW] ? CW'(-diff) : diff[CW-1:0];
    sq   = 64'(dmag) * 64'(dmag);
    dsum = 65'(dist_q) + 65'(sq);
  end

  // square root: one result bit per step
  logic [34:0] trial;
  logic [33:0] rrem_sh;
  assign rrem_sh = {rrem_q, rad_v_q[63:62]};
  assign trial   = {1'b0, rrem_sh} - {1'b0, root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    in_ch.ready  = (state_q == psb_pkg::ST_LOAD);
    out_ch.valid = (state_q == psb_pkg::ST_OUT);
    unique case (state_q)
      psb_pkg::ST_LOAD: if (acc_in && in_ch.data.is_last) state_d = psb_pkg::ST_DIV;
      psb_pkg::ST_DIV:  if (step_q == 6'(SW) && axis_q == 2'd2) state_d = psb_pkg::ST_RD;
      psb_pkg::ST_RD:   state_d = psb_pkg::ST_WALK;
      psb_pkg::ST_WALK: begin
        if (axis_q == 2'd2) begin
          state_d = (NW'(idx_q) + NW'(1) == cnt_q) ? psb_pkg::ST_SQRT : psb_pkg::ST_RD;
        end
      end
      psb_pkg::ST_SQRT: if (step_q == 6'd31) state_d = psb_pkg::ST_OUT;
      psb_pkg::ST_OUT:  if (out_ch.ready) state_d = psb_pkg::ST_LOAD;
      default:          state_d = psb_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psb_pkg::ST_LOAD;
      cnt_q   <= '0;
      smax_q  <= '0;
      axis_q  <= '0;
      step_q  <= '0;
      idx_q   <= '0;
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        psb_pkg::ST_LOAD: begin
          if (we) begin
            sum_q[0] <= sum_q[0] + SW'(in_ch.data.pos_x);
            sum_q[1] <= sum_q[1] + SW'(in_ch.data.pos_y);
            sum_q[2] <= sum_q[2] + SW'(in_ch.data.pos_z);
            if (cnt_q == '0 || in_ch.data.pos_x < lo_q[0]) lo_q[0] <= in_ch.data.pos_x;
            if (cnt_q == '0 || in_ch.data.pos_y < lo_q[1]) lo_q[1] <= in_ch.data.pos_y;
            if (cnt_q == '0 || in_ch.data.pos_z < lo_q[2]) lo_q[2] <= in_ch.data.pos_z;
            if (cnt_q == '0 || in_ch.data.pos_x > hi_q[0]) hi_q[0] <= in_ch.data.pos_x;
            if (cnt_q == '0 || in_ch.data.pos_y > hi_q[1]) hi_q[1] <= in_ch.data.pos_y;
            if (cnt_q == '0 || in_ch.data.pos_z > hi_q[2]) hi_q[2] <= in_ch.data.pos_z;
            if (in_ch.data.smooth_len > smax_q) smax_q <= in_ch.data.smooth_len;
            cnt_q <= cnt_q + NW'(1);
          end
          axis_q <= '0;
          step_q <= '0;
          idx_q  <= '0;
        end
        psb_pkg::ST_DIV: begin
          if (step_q == '0) begin
            quo_q <= div_abs;
            rem_q <= '0;
            neg_q <= div_src[SW-1];
            step_q <= step_q + 6'd1;
          end else if (step_q == 6'(SW)) begin
            ctr_q[axis_q] <= neg_q ? CW'(-{quo_q[SW-2:0], rem_ge})
                                   : CW'({quo_q[SW-2:0], rem_ge});
            step_q <= '0;
            axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
            dist_q <= '0;
            best_q <= '0;
          end else begin
            step_q <= step_q + 6'd1;
          end
          if (step_q != '0) begin
            rem_q <= rem_ge ? rem_sh - {1'b0, cnt_q} : rem_sh;
            quo_q <= {quo_q[SW-2:0], rem_ge};
          end
        end
        psb_pkg::ST_RD: begin
          dist_q <= '0;
          axis_q <= '0;
        end
        psb_pkg::ST_WALK: begin
          if (axis_q == 2'd2) begin
            axis_q <= '0;
            idx_q  <= idx_q + AW'(1);
            if ((dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0]) > best_q)
              best_q <= dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
            if (NW'(idx_q) + NW'(1) == cnt_q) begin
              rad_v_q <= ((dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0]) > best_q)
                         ? (dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0]) : best_q;
              root_q <= '0;
              rrem_q <= '0;
              step_q <= '0;
            end
          end else begin
            axis_q <= axis_q + 2'd1;
            dist_q <= dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
          end
        end
        psb_pkg::ST_SQRT: begin
          rad_v_q <= {rad_v_q[61:0], 2'b00};
          step_q  <= step_q + 6'd1;
          if (!trial[34]) begin
            rrem_q <= trial[31:0];
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rrem_q <= rrem_sh[31:0];
            root_q <= {root_q[30:0], 1'b0};
          end
        end
        psb_pkg::ST_OUT: begin
          if (out_ch.ready) begin
            cnt_q  <= '0;
            smax_q <= '0;
            for (int k = 0; k < 3; k++) sum_q[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.data.centre_x   = ctr_q[0];
  assign out_ch.data.centre_y   = ctr_q[1];
  assign out_ch.data.centre_z   = ctr_q[2];
  assign out_ch.data.min_x      = lo_q[0];
  assign out_ch.data.min_y      = lo_q[1];
  assign out_ch.data.min_z      = lo_q[2];
  assign out_ch.data.max_x      = hi_q[0];
  assign out_ch.data.max_y      = hi_q[1];
  assign out_ch.data.max_z      = hi_q[2];
  assign out_ch.data.radius     = root_q;
  assign out_ch.data.max_smooth = smax_q;
  assign out_ch.data.count      = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(psb_pkg::MaxParticles)) else $error("count past store depth");
  a_out_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> cnt_q != '0) else $error("result for empty set");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != psb_pkg::ST_LOAD |-> !in_ch.ready) else $error("ready while busy");
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> lo_q[0] <= hi_q[0] && lo_q[1] <= hi_q[1] && lo_q[2] <= hi_q[2])
    else $error("box inverted");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(root_q))
    else $error("result dropped");
endmodule

@@ rtl/core/psb_ram.sv @@
// ----------------------------------------------------------------------------
// psb_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module psb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
